// ===== design/usm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// usm_pkg
// Shared constants and tables of the UV sphere mesh generator.
// ============================================================================
package usm_pkg;

    // configuration register indexes
    localparam logic CFG_SLICE_COUNT = 1'b0;
    localparam logic CFG_RING_COUNT  = 1'b1;

    localparam int CFG_W        = 11;
    localparam int MAX_SEGMENTS = 1024;
    localparam int MIN_SLICES   = 3;
    localparam int MIN_RINGS    = 1;

    // fixed point formats
    localparam int COORD_FRAC_BITS = 14;
    localparam int CORDIC_FRAC     = 30;
    localparam int CORDIC_STEPS    = 30;
    localparam int CORDIC_W        = 34;
    localparam int PHASE_W         = 32;
    localparam logic [CORDIC_W-1:0] CORDIC_INV_GAIN = 34'd652032874;

    // atan(2^-i) as a fraction of a turn, one turn = 2^32
    localparam logic [PHASE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

endpackage

// ===== design/usm_delay.sv =====
`timescale 1ns / 1ps
// ============================================================================
// usm_delay
// Stallable delay line for sideband data with a valid bit per stage.
// ============================================================================
module usm_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [W-1:0]     data_reg [DEPTH];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    // data chain, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

// ===== design/usm_divider.sv =====
`timescale 1ns / 1ps
// ============================================================================
// usm_divider
// Pipelined restoring divider, one quotient bit per stage.
// Dividend must stay below divisor * 2^QW for an exact result.
// ============================================================================
module usm_divider #(
    parameter int DW = 11,
    parameter int QW = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DW+QW-1:0] dividend,
    input  logic [DW-1:0]    divisor,
    output logic [QW-1:0]    quotient,
    output logic [DW-1:0]    remainder
);

    localparam int NW = DW + QW;

    logic [NW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] dvs_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int B = QW - 1 - i;
        logic [NW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] dvs_in;
        logic [NW-1:0] shifted;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = dividend;
            assign quo_in = '0;
            assign dvs_in = divisor;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
        end

        // trial subtract of the shifted divisor
        assign shifted = NW'(dvs_in) << B;
        assign ge      = (rem_in >= shifted);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? (rem_in - shifted) : rem_in;
                quo_reg[i] <= quo_in | (QW'(ge) << B);
                dvs_reg[i] <= dvs_in;
            end
        end
    end

    assign quotient  = quo_reg[QW-1];
    assign remainder = rem_reg[QW-1][DW-1:0];

endmodule

// ===== design/usm_cordic.sv =====
`timescale 1ns / 1ps
// ============================================================================
// usm_cordic
// Pipelined rotation CORDIC: Q30 cosine and sine of a 32-bit turn phase.
// One folding stage, then one stage per iteration.
// ============================================================================
module usm_cordic (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [usm_pkg::PHASE_W-1:0]          phase,
    output logic signed [usm_pkg::CORDIC_W-1:0]  cos_out,
    output logic signed [usm_pkg::CORDIC_W-1:0]  sin_out
);

    import usm_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                       flip_reg [CORDIC_STEPS+1];

    // fold phase into the right half plane
    logic [PHASE_W-1:0] phase_off;
    logic [PHASE_W-1:0] phase_fold;
    logic               flip;

    assign phase_off  = phase + 32'h4000_0000;
    assign flip       = phase_off[PHASE_W-1];
    assign phase_fold = flip ? (phase - 32'h8000_0000) : phase;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_INV_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(CORDIC_W-PHASE_W){phase_fold[PHASE_W-1]}}, phase_fold};
            flip_reg[0] <= flip;
        end
    end

    // micro-rotations
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [CORDIC_W-1:0] da;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign da = CORDIC_W'(ATAN_TURN[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CORDIC_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - da;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + da;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // undo the fold
    assign cos_out = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign sin_out = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];

endmodule

// ===== design/usm_out_buf.sv =====
`timescale 1ns / 1ps
// ============================================================================
// usm_out_buf
// Two-entry output buffer that parts the pipeline from the result receiver.
// ============================================================================
module usm_out_buf #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [W-1:0] m_data
);

    logic [1:0]   count_reg;
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [W-1:0] mem_reg [2];
    logic         pop;

    assign pop     = m_valid && m_ready;
    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/uv_sphere_mesh_generator_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// uv_sphere_mesh_generator_core
// UV sphere vertex positions and triangle indices on request.
// ============================================================================
// Usage:
//   Slave stream: s_tuser is the command (0 vertex, 1 triangle), s_tdata
//   carries the vertex or triangle index. Master stream: one result per
//   request, positions in s1.14 and corner indices in m_tdata, the index
//   out-of-range flag in m_tuser.
//   slice_count and ring_count are written on the cfg port while the block
//   is idle; out-of-range values are clamped on use.
//   Throughput: one request per cycle while the output buffer is not full.
//   Path from accept to m_tvalid: the request stages, the 11-stage index divider,
//   the 32-stage phase dividers, the 31-stage CORDIC and the multiply/round stages.
//   Reset: pipeline and output buffer empty, slice_count = 8, ring_count = 4.
//   Stall: a two-entry output buffer holds results; the whole pipeline
//   holds when that buffer is full, and s_tready drops with it. Nothing is
//   lost or repeated.
// ============================================================================
module uv_sphere_mesh_generator_core (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [usm_pkg::CFG_W-1:0] cfg_data,
    // request stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // item_index[20:0], zero pad
    input  logic                      s_tuser,   // command
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], corner_a[68:48],
    // corner_b[89:69], corner_c[110:90], zero pad
    output logic [111:0]              m_tdata,
    output logic                      m_tuser    // out_of_range
);

    import usm_pkg::*;

    localparam int IDX_W   = 21;
    localparam int WIDE_W  = 22;
    localparam int D1_Q    = 11;
    localparam int D1_D    = 12;
    localparam int D2_Q    = 32;
    localparam int D2_D    = CFG_W;
    localparam int PROD_W  = 2 * CORDIC_W;
    localparam int PROD_SH = 2 * CORDIC_FRAC - COORD_FRAC_BITS;
    localparam int SIN_SH  = CORDIC_FRAC - COORD_FRAC_BITS;
    localparam int TAIL_D  = D2_Q + CORDIC_STEPS + 3;
    localparam logic signed [15:0] ONE = 16'sd16384;

    typedef enum logic [1:0] {CLS_FAN_BOT, CLS_MID, CLS_FAN_TOP} tri_cls_t;

    typedef struct packed {
        logic             cmd;
        logic             oor;
        logic             pole_lo;
        logic             pole_hi;
        tri_cls_t         cls;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] s;
        logic [CFG_W-1:0] r;
        logic [IDX_W-1:0] sr;
    } side1_t;

    typedef struct packed {
        logic             cmd;
        logic             oor;
        logic             pole_lo;
        logic             pole_hi;
        logic [IDX_W-1:0] ca;
        logic [IDX_W-1:0] cb;
        logic [IDX_W-1:0] cc;
    } side2_t;

    // ------------------------------------------------------------------
    // configuration registers
    logic [CFG_W-1:0] slice_count_reg;
    logic [CFG_W-1:0] ring_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= 11'd8;
            ring_count_reg  <= 11'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLICE_COUNT: slice_count_reg <= cfg_data;
                CFG_RING_COUNT:  ring_count_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic [CFG_W-1:0] s_clamp;
    logic [CFG_W-1:0] r_clamp;

    assign s_clamp = (slice_count_reg < CFG_W'(MIN_SLICES))   ? CFG_W'(MIN_SLICES) :
                     (slice_count_reg > CFG_W'(MAX_SEGMENTS)) ? CFG_W'(MAX_SEGMENTS) :
                     slice_count_reg;
    assign r_clamp = (ring_count_reg < CFG_W'(MIN_RINGS))     ? CFG_W'(MIN_RINGS) :
                     (ring_count_reg > CFG_W'(MAX_SEGMENTS))  ? CFG_W'(MAX_SEGMENTS) :
                     ring_count_reg;

    // ------------------------------------------------------------------
    // global advance: hold everything while the output buffer is full
    logic en;
    logic buf_full;

    assign en       = !buf_full;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // stage 0: capture request and clamped config
    logic             v0_reg;
    logic             cmd0_reg;
    logic [IDX_W-1:0] idx0_reg;
    logic [CFG_W-1:0] s0_reg;
    logic [CFG_W-1:0] r0_reg;

    // stage 1: slices times rings
    logic             v1_reg;
    logic             cmd1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [CFG_W-1:0] s1_reg;
    logic [CFG_W-1:0] r1_reg;
    logic [IDX_W-1:0] sr1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd0_reg <= s_tuser;
            idx0_reg <= s_tdata[IDX_W-1:0];
            s0_reg   <= s_clamp;
            r0_reg   <= r_clamp;
            cmd1_reg <= cmd0_reg;
            idx1_reg <= idx0_reg;
            s1_reg   <= s0_reg;
            r1_reg   <= r0_reg;
            // full-width product, up to 1024 * 1024
            sr1_reg  <= IDX_W'(s0_reg) * IDX_W'(r0_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: range checks, class and index divider operands
    logic [WIDE_W-1:0] idx_w;
    logic [WIDE_W-1:0] nv;
    logic [WIDE_W-1:0] nt;
    logic [WIDE_W-1:0] mid_end;
    side1_t            side2_next;
    logic [D1_Q+D1_D-1:0] dvd1_next;
    logic [D1_D-1:0]      dvs1_next;

    assign idx_w   = WIDE_W'(idx1_reg);
    assign nv      = WIDE_W'(sr1_reg) + WIDE_W'(2);
    assign nt      = {sr1_reg, 1'b0};
    assign mid_end = nt - WIDE_W'(s1_reg);

    always_comb
    begin
        side2_next.cmd     = cmd1_reg;
        side2_next.idx     = idx1_reg;
        side2_next.s       = s1_reg;
        side2_next.r       = r1_reg;
        side2_next.sr      = sr1_reg;
        side2_next.pole_lo = (idx1_reg == '0);
        side2_next.pole_hi = (idx_w == nv - WIDE_W'(1));
        side2_next.oor     = cmd1_reg ? (idx_w >= nt) : (idx_w >= nv);
        if (idx_w < WIDE_W'(s1_reg))
        begin
            side2_next.cls = CLS_FAN_BOT;
        end
        else if (idx_w < mid_end)
        begin
            side2_next.cls = CLS_MID;
        end
        else
        begin
            side2_next.cls = CLS_FAN_TOP;
        end
        if (cmd1_reg)
        begin
            dvd1_next = (D1_Q+D1_D)'(idx1_reg - IDX_W'(s1_reg));
            dvs1_next = {s1_reg, 1'b0};
        end
        else
        begin
            dvd1_next = (D1_Q+D1_D)'(idx1_reg - IDX_W'(1));
            dvs1_next = D1_D'(s1_reg);
        end
    end

    logic                 v2_reg;
    side1_t               side2_reg;
    logic [D1_Q+D1_D-1:0] dvd1_reg;
    logic [D1_D-1:0]      dvs1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side2_next;
            dvd1_reg  <= dvd1_next;
            dvs1_reg  <= dvs1_next;
        end
    end

    // ------------------------------------------------------------------
    // index divider: ring and slice, or strip and position in strip
    logic [D1_Q-1:0]        q1;
    logic [D1_D-1:0]        rem1;
    logic                   v_d1;
    logic [$bits(side1_t)-1:0] side_d1_raw;
    side1_t                 sd;

    usm_divider #(
        .DW (D1_D),
        .QW (D1_Q)
    ) u_div_index (
        .clk       (clk),
        .en        (en),
        .dividend  (dvd1_reg),
        .divisor   (dvs1_reg),
        .quotient  (q1),
        .remainder (rem1)
    );

    usm_delay #(
        .W     ($bits(side1_t)),
        .DEPTH (D1_Q)
    ) u_delay_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_data   (side2_reg),
        .out_valid (v_d1),
        .out_data  (side_d1_raw)
    );

    assign sd = side1_t'(side_d1_raw);

    // ------------------------------------------------------------------
    // stage 3: phase divider operands and triangle corners
    logic [CFG_W-1:0]     ring1;
    logic [D2_Q+D2_D-1:0] lat_dvd_next;
    logic [D2_Q+D2_D-1:0] lon_dvd_next;
    logic [D2_D-1:0]      lat_dvs_next;
    logic [WIDE_W-1:0]    ys;
    logic [WIDE_W-1:0]    ys_s;
    logic [WIDE_W-1:0]    m_mid;
    logic [WIDE_W-1:0]    mn_mid;
    logic [WIDE_W-1:0]    base_top;
    logic [WIDE_W-1:0]    m_top;
    logic [WIDE_W-1:0]    m_top_wrap;
    logic [WIDE_W-1:0]    s_w;
    logic [WIDE_W-1:0]    sidx_w;
    logic [WIDE_W-1:0]    ca_w;
    logic [WIDE_W-1:0]    cb_w;
    logic [WIDE_W-1:0]    cc_w;
    side2_t               side3_next;

    assign ring1        = q1 + CFG_W'(1);
    assign lat_dvd_next = (D2_Q+D2_D)'(ring1) << 31;
    assign lat_dvs_next = sd.r + CFG_W'(1);
    assign lon_dvd_next = (D2_Q+D2_D)'(rem1[CFG_W-1:0]) << 32;

    assign s_w        = WIDE_W'(sd.s);
    assign sidx_w     = WIDE_W'(sd.idx);
    assign ys         = WIDE_W'(q1) * s_w;
    assign ys_s       = ys + s_w;
    assign m_mid      = WIDE_W'(rem1 >> 1) + WIDE_W'(1);
    assign mn_mid     = (m_mid == s_w) ? WIDE_W'(1) : (m_mid + WIDE_W'(1));
    assign base_top   = WIDE_W'(sd.sr) - s_w;
    assign m_top      = sidx_w - ({sd.sr, 1'b0} - s_w) + WIDE_W'(1);
    assign m_top_wrap = (m_top == s_w) ? '0 : m_top;

    always_comb
    begin
        ca_w = '0;
        cb_w = '0;
        cc_w = '0;
        if (sd.cmd)
        begin
            case (sd.cls)
                CLS_FAN_BOT:
                begin
                    ca_w = (sidx_w + WIDE_W'(1) == s_w) ? WIDE_W'(1) : (sidx_w + WIDE_W'(2));
                    cc_w = sidx_w + WIDE_W'(1);
                end
                CLS_MID:
                begin
                    ca_w = ys + m_mid;
                    if (!rem1[0])
                    begin
                        cb_w = ys_s + m_mid;
                        cc_w = ys_s + mn_mid;
                    end
                    else
                    begin
                        cb_w = ys_s + mn_mid;
                        cc_w = ys + mn_mid;
                    end
                end
                default:
                begin
                    ca_w = base_top + m_top;
                    cb_w = WIDE_W'(sd.sr) + WIDE_W'(1);
                    cc_w = base_top + m_top_wrap + WIDE_W'(1);
                end
            endcase
        end
        side3_next.cmd     = sd.cmd;
        side3_next.oor     = sd.oor;
        side3_next.pole_lo = sd.pole_lo;
        side3_next.pole_hi = sd.pole_hi;
        side3_next.ca      = ca_w[IDX_W-1:0];
        side3_next.cb      = cb_w[IDX_W-1:0];
        side3_next.cc      = cc_w[IDX_W-1:0];
    end

    logic                 v3_reg;
    side2_t               side3_reg;
    logic [D2_Q+D2_D-1:0] lat_dvd_reg;
    logic [D2_Q+D2_D-1:0] lon_dvd_reg;
    logic [D2_D-1:0]      lat_dvs_reg;
    logic [D2_D-1:0]      lon_dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v_d1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg   <= side3_next;
            lat_dvd_reg <= lat_dvd_next;
            lon_dvd_reg <= lon_dvd_next;
            lat_dvs_reg <= lat_dvs_next;
            lon_dvs_reg <= sd.s;
        end
    end

    // ------------------------------------------------------------------
    // phase dividers
    logic [D2_Q-1:0] lat_q;
    logic [D2_Q-1:0] lon_q;
    logic [D2_D-1:0] lat_rem;
    logic [D2_D-1:0] lon_rem;
    logic [PHASE_W-1:0] lat_phase;

    usm_divider #(
        .DW (D2_D),
        .QW (D2_Q)
    ) u_div_lat (
        .clk       (clk),
        .en        (en),
        .dividend  (lat_dvd_reg),
        .divisor   (lat_dvs_reg),
        .quotient  (lat_q),
        .remainder (lat_rem)
    );

    usm_divider #(
        .DW (D2_D),
        .QW (D2_Q)
    ) u_div_lon (
        .clk       (clk),
        .en        (en),
        .dividend  (lon_dvd_reg),
        .divisor   (lon_dvs_reg),
        .quotient  (lon_q),
        .remainder (lon_rem)
    );

    // latitude starts a quarter turn below the equator
    assign lat_phase = lat_q - 32'h4000_0000;

    // ------------------------------------------------------------------
    // sine and cosine
    logic signed [CORDIC_W-1:0] lat_cos;
    logic signed [CORDIC_W-1:0] lat_sin;
    logic signed [CORDIC_W-1:0] lon_cos;
    logic signed [CORDIC_W-1:0] lon_sin;

    usm_cordic u_cordic_lat (
        .clk     (clk),
        .en      (en),
        .phase   (lat_phase),
        .cos_out (lat_cos),
        .sin_out (lat_sin)
    );

    usm_cordic u_cordic_lon (
        .clk     (clk),
        .en      (en),
        .phase   (lon_q),
        .cos_out (lon_cos),
        .sin_out (lon_sin)
    );

    // ------------------------------------------------------------------
    // multiply stage
    logic signed [PROD_W-1:0]   px_prod_reg;
    logic signed [PROD_W-1:0]   pz_prod_reg;
    logic signed [CORDIC_W-1:0] sin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_prod_reg <= lat_cos * lon_cos;
            pz_prod_reg <= lat_cos * lon_sin;
            sin_reg     <= lat_sin;
        end
    end

    // ------------------------------------------------------------------
    // round half up and saturate
    function automatic logic signed [15:0] sat_coord(input logic signed [PROD_W-1:0] v);
        if (v > PROD_W'(ONE))
        begin
            return ONE;
        end
        else if (v < -PROD_W'(ONE))
        begin
            return -ONE;
        end
        return v[15:0];
    endfunction

    logic signed [PROD_W-1:0]   px_sum;
    logic signed [PROD_W-1:0]   pz_sum;
    logic signed [CORDIC_W-1:0] py_sum;
    logic signed [PROD_W-1:0]   py_ext;
    logic signed [15:0]         px_reg;
    logic signed [15:0]         py_reg;
    logic signed [15:0]         pz_reg;

    assign px_sum = px_prod_reg + (PROD_W'(1) <<< (PROD_SH - 1));
    assign pz_sum = pz_prod_reg + (PROD_W'(1) <<< (PROD_SH - 1));
    assign py_sum = sin_reg + (CORDIC_W'(1) <<< (SIN_SH - 1));
    assign py_ext = PROD_W'(py_sum >>> SIN_SH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= sat_coord(px_sum >>> PROD_SH);
            pz_reg <= sat_coord(pz_sum >>> PROD_SH);
            py_reg <= sat_coord(py_ext);
        end
    end

    // ------------------------------------------------------------------
    // sideband alignment with the arithmetic tail
    logic                      v_tail;
    logic [$bits(side2_t)-1:0] side_tail_raw;
    side2_t                    st;

    usm_delay #(
        .W     ($bits(side2_t)),
        .DEPTH (TAIL_D)
    ) u_delay_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_data   (side3_reg),
        .out_valid (v_tail),
        .out_data  (side_tail_raw)
    );

    assign st = side2_t'(side_tail_raw);

    // ------------------------------------------------------------------
    // result select
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
    logic [IDX_W-1:0]   oa;
    logic [IDX_W-1:0]   ob;
    logic [IDX_W-1:0]   oc;

    always_comb
    begin
        ox = '0;
        oy = '0;
        oz = '0;
        oa = '0;
        ob = '0;
        oc = '0;
        if (!st.oor)
        begin
            if (st.cmd)
            begin
                oa = st.ca;
                ob = st.cb;
                oc = st.cc;
            end
            else if (st.pole_lo)
            begin
                oy = -ONE;
            end
            else if (st.pole_hi)
            begin
                oy = ONE;
            end
            else
            begin
                ox = px_reg;
                oy = py_reg;
                oz = pz_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // output buffer
    logic [112:0] buf_out;

    usm_out_buf #(
        .W (113)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && v_tail),
        .push_data ({st.oor, 1'b0, oc, ob, oa, oz, oy, ox}),
        .full      (buf_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (buf_out)
    );

    assign m_tdata = buf_out[111:0];
    assign m_tuser = buf_out[112];

    // ------------------------------------------------------------------
    // assertions
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("out-of-range result carries nonzero data");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:0] == '0) || (m_tdata[110:48] == '0))
        else $error("result carries both position and corners");

    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) >= -16'sd16384)
                  && ($signed(m_tdata[31:16]) <= 16'sd16384))
        else $error("pos_y outside unit range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full |=> $stable(v3_reg) && $stable(side3_reg))
        else $error("pipeline moved while output buffer full");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for uv_sphere_mesh_generator_core.
// A short table of directed requests runs at the reset configuration. It is
// followed by random vertex and triangle requests under several slice and
// ring settings, the extremes among them. Both stream sides idle at random.
// Each result is compared field by field with a local CORDIC and index
// predictor.
// ============================================================================
module testbench;

    import usm_pkg::*;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [20:0]        ca;
        logic [20:0]        cb;
        logic [20:0]        cc;
        logic               oor;
    } answer_t;

    typedef struct {
        logic        cmd;
        logic [20:0] idx;
        bit          known;
        answer_t     ans;
    } row_t;

    localparam int  STALL_LIMIT = 2000;
    localparam int  PHASE_ITEMS = 200;
    localparam logic CMD_VERTEX   = 1'b0;
    localparam logic CMD_TRIANGLE = 1'b1;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = CFG_SLICE_COUNT;
    logic [10:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [111:0] m_tdata;
    logic         m_tuser;

    answer_t      answers_due[$];
    logic [10:0]  slices_reg = 11'd8;
    logic [10:0]  rings_reg  = 11'd4;
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           hold_left = 0;
    bit           calm = 1'b0;

    uv_sphere_mesh_generator_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // cosine and sine of a turn phase, Q30
    function automatic void turn_sincos(input logic [31:0] phase,
                                        output longint c, output longint s);
        logic [31:0] p;
        bit          flip;
        longint      x, y, z, dx, dy;
        p = phase;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (((p + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            p = p - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(p));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TURN[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TURN[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // round half up by sh bits, then saturate to +/-1.0
    function automatic logic signed [15:0] to_coord(input longint v, input int sh);
        longint r;
        r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic longint unsigned eff_slices();
        return slices_reg < 3 ? 3 : (slices_reg > MAX_SEGMENTS ? MAX_SEGMENTS : slices_reg);
    endfunction

    function automatic longint unsigned eff_rings();
        return rings_reg < 1 ? 1 : (rings_reg > MAX_SEGMENTS ? MAX_SEGMENTS : rings_reg);
    endfunction

    function automatic answer_t sphere_answer(input logic cmd, input logic [20:0] index);
        answer_t a;
        longint unsigned s, r, idx, nv, nt, mid, t, ring, k, j, y, w, m, mn, base;
        logic [31:0] lat, lon;
        longint lc, ls, oc, os;
        a = '0;
        s = eff_slices();
        r = eff_rings();
        idx = index;
        if (cmd == CMD_VERTEX)
        begin
            nv = 2 + s * r;
            if (idx >= nv) a.oor = 1'b1;
            else if (idx == 0) a.py = -16'sd16384;
            else if (idx == nv - 1) a.py = 16'sd16384;
            else
            begin
                t = idx - 1; ring = t / s; k = t % s;
                lat = 32'((((ring + 1) << 31) / (r + 1)) - 64'h4000_0000);
                lon = 32'((k << 32) / s);
                turn_sincos(lat, lc, ls);
                turn_sincos(lon, oc, os);
                a.py = to_coord(ls, 30 - COORD_FRAC_BITS);
                a.px = to_coord(lc * oc, 60 - COORD_FRAC_BITS);
                a.pz = to_coord(lc * os, 60 - COORD_FRAC_BITS);
            end
        end
        else
        begin
            nt = 2 * s * r;
            mid = 2 * s * (r - 1);
            if (idx >= nt) a.oor = 1'b1;
            else if (idx < s)
            begin
                a.ca = 21'((idx + 1) % s + 1); a.cb = '0; a.cc = 21'(idx + 1);
            end
            else if (idx < s + mid)
            begin
                j = idx - s; y = j / (2 * s); w = j % (2 * s);
                m = w / 2 + 1; mn = m % s + 1;
                a.ca = 21'(y * s + m);
                if (w[0] == 1'b0)
                begin
                    a.cb = 21'((y + 1) * s + m); a.cc = 21'((y + 1) * s + mn);
                end
                else
                begin
                    a.cb = 21'((y + 1) * s + mn); a.cc = 21'(y * s + mn);
                end
            end
            else
            begin
                m = idx - s - mid + 1; base = s * (r - 1);
                a.ca = 21'(base + m); a.cb = 21'(s * r + 1); a.cc = 21'(base + m % s + 1);
            end
        end
        return a;
    endfunction

    // one request transaction, with a random lead-in gap
    task automatic send_request(input logic cmd, input logic [20:0] idx,
                                input bit known, input answer_t ans);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, idx};
        do @(posedge clk); while (!s_tready);
        answers_due.insert(answers_due.size(), known ? ans : sphere_answer(cmd, idx));
    endtask

    // register write, only with the pipeline drained
    task automatic write_config(input logic [10:0] slices, input logic [10:0] rings);
        s_tvalid <= 1'b0;
        wait (answers_due.size() == 0);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= CFG_SLICE_COUNT; cfg_data <= slices;
        @(posedge clk);
        cfg_index <= CFG_RING_COUNT; cfg_data <= rings;
        @(posedge clk);
        cfg_we <= 1'b0;
        slices_reg = slices;
        rings_reg  = rings;
    endtask

    function automatic logic [20:0] pick_index(input logic cmd);
        longint unsigned cnt;
        cnt = (cmd == CMD_VERTEX) ? 2 + eff_slices() * eff_rings()
                                  : 2 * eff_slices() * eff_rings();
        if (cnt > 64'h20_0000) cnt = 64'h20_0000;
        case ($urandom_range(0, 9)) inside
            7:       return 21'(($urandom_range(0, 3) == 0) ? 0 :
                                ($urandom_range(0, 1) ? cnt - 1 : cnt));
            8, 9:    return 21'($urandom);
            default: return 21'($urandom_range(0, 32'(cnt - 1)));
        endcase
    endfunction

    // result check against the oldest expectation; random back-pressure
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                answer_t e;
                answer_t g;
                e = answers_due.pop_front();
                g.px = m_tdata[15:0];   g.py = m_tdata[31:16];  g.pz = m_tdata[47:32];
                g.ca = m_tdata[68:48];  g.cb = m_tdata[89:69];  g.cc = m_tdata[110:90];
                g.oor = m_tuser;
                if (g.px !== e.px)
                    $display("%0t: pos_x exp %0d got %0d", $time, e.px, g.px);
                if (g.py !== e.py)
                    $display("%0t: pos_y exp %0d got %0d", $time, e.py, g.py);
                if (g.pz !== e.pz)
                    $display("%0t: pos_z exp %0d got %0d", $time, e.pz, g.pz);
                if (g.ca !== e.ca)
                    $display("%0t: corner_a exp %0d got %0d", $time, e.ca, g.ca);
                if (g.cb !== e.cb)
                    $display("%0t: corner_b exp %0d got %0d", $time, e.cb, g.cb);
                if (g.cc !== e.cc)
                    $display("%0t: corner_c exp %0d got %0d", $time, e.cc, g.cc);
                if (g.oor !== e.oor)
                    $display("%0t: out_of_range exp %0d got %0d", $time, e.oor, g.oor);
                if (g !== e) mismatches++;
            end
            hold_left = calm ? 0 : $urandom_range(0, 12);
            if (hold_left != 0) m_tready <= 1'b0;
        end
        else if (!m_tready)
        begin
            if (hold_left <= 1) m_tready <= 1'b1;
            hold_left--;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus
    initial
    begin
        row_t        rows[$];
        logic [10:0] cfg_s[9];
        logic [10:0] cfg_r[9];
        logic        cmd;
        answer_t     z;
        z = '0;
        // directed table at reset settings: 8 slices, 4 rings
        rows = '{
            '{CMD_VERTEX,   21'd0,       1, '{0, -16384, 0, 0, 0, 0, 0}},
            '{CMD_VERTEX,   21'd33,      1, '{0, 16384, 0, 0, 0, 0, 0}},
            '{CMD_VERTEX,   21'd34,      1, '{0, 0, 0, 0, 0, 0, 1}},
            '{CMD_VERTEX,   21'h1F_FFFF, 1, '{0, 0, 0, 0, 0, 0, 1}},
            '{CMD_VERTEX,   21'd1,       0, z},
            '{CMD_VERTEX,   21'd5,       0, z},
            '{CMD_VERTEX,   21'd17,      0, z},
            '{CMD_VERTEX,   21'd32,      0, z},
            '{CMD_TRIANGLE, 21'd0,       1, '{0, 0, 0, 2, 0, 1, 0}},
            '{CMD_TRIANGLE, 21'd7,       1, '{0, 0, 0, 1, 0, 8, 0}},
            '{CMD_TRIANGLE, 21'd8,       1, '{0, 0, 0, 1, 9, 10, 0}},
            '{CMD_TRIANGLE, 21'd9,       1, '{0, 0, 0, 1, 10, 2, 0}},
            '{CMD_TRIANGLE, 21'd30,      0, z},
            '{CMD_TRIANGLE, 21'd63,      1, '{0, 0, 0, 32, 33, 25, 0}},
            '{CMD_TRIANGLE, 21'd64,      1, '{0, 0, 0, 0, 0, 0, 1}},
            '{CMD_TRIANGLE, 21'h1F_FFFF, 1, '{0, 0, 0, 0, 0, 0, 1}}
        };
        cfg_s = '{11'd3, 11'd1024, 11'd0, 11'd2047, 11'd17, 11'd8, 11'd5, 11'd0, 11'd0};
        cfg_r = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd3, 11'd4, 11'd9, 11'd0, 11'd0};
        cfg_s[7] = 11'($urandom); cfg_r[7] = 11'($urandom);
        cfg_s[8] = 11'($urandom_range(3, 40)); cfg_r[8] = 11'($urandom_range(1, 40));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_request(rows[i].cmd, rows[i].idx, rows[i].known, rows[i].ans);

        // random phases, one setting each
        for (int p = 0; p < 9; p++)
        begin
            write_config(cfg_s[p], cfg_r[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
                cmd = $urandom_range(0, 1);
                send_request(cmd, pick_index(cmd), 0, z);
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        wait (answers_due.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== uv_sphere_mesh_generator_core.f =====
design/usm_pkg.sv
design/usm_delay.sv
design/usm_divider.sv
design/usm_cordic.sv
design/usm_out_buf.sv
design/uv_sphere_mesh_generator_core.sv
sim/testbench.sv
